// ----- sv/fvn_pkg.sv -----
`timescale 1ns / 1ps
// Package for the fractal value noise core: sizes, hash constants, types.
// No dependencies; imported by fvn_weights and fractal_value_noise_1d_core.
package fvn_pkg;
	localparam int MAX_OCTAVES = 8;
	localparam int FRAC_BITS   = 16;
	localparam int POS_W       = 32 + FRAC_BITS;
	localparam int OCT_IW      = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int AMP_W       = 17;
	localparam int SUM_W       = AMP_W + $clog2(MAX_OCTAVES + 1);
	localparam int RECIP_W     = 25;
	localparam int DIV_STEPS   = 41;
	localparam int DIV_CW      = $clog2(DIV_STEPS);
	localparam int V_W         = 33 + $clog2(MAX_OCTAVES + 1);
	localparam int RLO_W       = 13;
	localparam int RHI_W       = RECIP_W - RLO_W;

	localparam logic [31:0] SEED_MUL  = 32'd57;
	localparam logic [31:0] HASH_M1   = 32'd15731;
	localparam logic [31:0] HASH_A1   = 32'd789221;
	localparam logic [31:0] HASH_A2   = 32'd1376312589;
	localparam logic [AMP_W-1:0] ONE_Q16 = AMP_W'(65536);

	localparam logic [1:0] REG_SEED    = 2'd0;
	localparam logic [1:0] REG_OCTAVES = 2'd1;
	localparam logic [1:0] REG_PERSIST = 2'd2;

	typedef enum logic [1:0] {
		WT_IDLE,
		WT_AMP,
		WT_DIV
	} wt_state_t;

	typedef struct packed {
		logic [MAX_OCTAVES-1:0][AMP_W-1:0] amp;
		logic [RECIP_W-1:0]                recip;
	} weights_t;
endpackage

// ----- sv/fvn_weights.sv -----
`timescale 1ns / 1ps
// Octave weight unit: per-octave amplitudes and reciprocal of their sum.
// Depends on fvn_pkg; sequential amplitude pass then restoring division.
module fvn_weights (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 kick,
	input  logic [3:0]           octave_count,
	input  logic [15:0]          persistence_q16,
	output fvn_pkg::weights_t    weights,
	output logic                 busy
);
	import fvn_pkg::*;

	wt_state_t state_q, state_d;
	logic [OCT_IW-1:0]  idx_q;
	logic [DIV_CW-1:0]  dcnt_q;
	logic [AMP_W-1:0]   a_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [MAX_OCTAVES-1:0][AMP_W-1:0] amp_q;
	logic [4:0]         n_used;
	logic               in_use;
	logic [32:0]        a_prod;
	logic [SUM_W:0]     trial;
	logic               take;
	logic               last_oct;

	always_comb begin
		n_used = {1'b0, octave_count};
		if (octave_count == 4'd0) n_used = 5'd1;
		if (n_used > 5'(MAX_OCTAVES)) n_used = 5'(MAX_OCTAVES);
		in_use   = {{(32-OCT_IW){1'b0}}, idx_q} < 32'(n_used);
		a_prod   = {16'd0, a_q} * {17'd0, persistence_q16};
		trial    = {rem_q, (dcnt_q == DIV_CW'(DIV_STEPS - 1))};
		take     = trial >= {1'b0, sum_q};
		last_oct = idx_q == OCT_IW'(MAX_OCTAVES - 1);
	end

	// A kick restarts the pass from the first octave, even mid-pass.
	always_comb begin
		state_d = state_q;
		if (kick) begin
			state_d = WT_AMP;
		end else begin
			case (state_q)
				WT_IDLE: state_d = WT_IDLE;
				WT_AMP:  if (last_oct) state_d = WT_DIV;
				WT_DIV:  if (dcnt_q == '0) state_d = WT_IDLE;
				default: state_d = WT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WT_AMP;
			idx_q   <= '0;
			dcnt_q  <= DIV_CW'(DIV_STEPS - 1);
			a_q     <= ONE_Q16;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (kick) begin
				idx_q  <= '0;
				dcnt_q <= DIV_CW'(DIV_STEPS - 1);
				a_q    <= ONE_Q16;
				sum_q  <= '0;
			end else begin
				case (state_q)
					WT_IDLE: begin
						idx_q  <= '0;
						dcnt_q <= DIV_CW'(DIV_STEPS - 1);
						a_q    <= ONE_Q16;
						sum_q  <= '0;
					end
					WT_AMP: begin
						idx_q <= idx_q + OCT_IW'(1);
						a_q   <= a_prod[32:16];
						if (in_use) sum_q <= sum_q + SUM_W'(a_q);
					end
					WT_DIV: dcnt_q <= dcnt_q - DIV_CW'(1);
					default: ;
				endcase
			end
		end
	end

	// Amplitudes, remainder and quotient are payload; the reset pass fills them.
	always_ff @(posedge clk) begin
		if (state_q == WT_AMP) begin
			amp_q[idx_q] <= in_use ? a_q : '0;
			rem_q        <= '0;
		end
		if (state_q == WT_DIV) begin
			rem_q <= take ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
			quo_q <= {quo_q[RECIP_W-2:0], take};
		end
	end

	assign weights.amp   = amp_q;
	assign weights.recip = quo_q;
	assign busy          = (state_q != WT_IDLE) || kick;
endmodule

// ----- sv/fractal_value_noise_1d_core.sv -----
`timescale 1ns / 1ps
// Top level of the 1-D fractal value noise core: nine-stage sample pipeline.
// Depends on fvn_pkg and fvn_weights.
//
//  channel   ports                                 transaction when
//  input     start, busy, position                 start && !busy at clk edge
//  result    done, noise_value                     done high (one cycle)
//  config    cfg_we, cfg_index, cfg_data           cfg_we at clk edge
//
// One sample enters per cycle while busy is low; done rises when the sample's
// result reaches the stage 9 register, and it is taken at the clk edge while done is high.
// The hash multiplier chain (three dependent 32-bit products per lattice
// point) and the final weight normalization set the depth.
// After reset, and after every write of octave_count or persistence_q16, busy
// stays high while the weight unit walks the 8 octaves and divides 2^40 by
// the weight sum one quotient bit per cycle (41 bits); a write during that
// pass restarts it.
// The receiver cannot stall, so the pipeline never holds.
module fractal_value_noise_1d_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [fvn_pkg::POS_W-1:0] position,
	output logic                        done,
	output logic [15:0]                 noise_value,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data
);
	import fvn_pkg::*;

	localparam int L = MAX_OCTAVES;

	// Configuration registers.
	logic [31:0] seed57_q;
	logic [3:0]  octaves_q;
	logic [15:0] persist_q;
	logic        kick_q;
	weights_t    wts;
	logic        wt_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed57_q  <= '0;
			octaves_q <= 4'd5;
			persist_q <= 16'd36045;
			kick_q    <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SEED:    seed57_q <= cfg_data * SEED_MUL;
					REG_OCTAVES: begin
						octaves_q <= cfg_data[3:0];
						kick_q    <= 1'b1;
					end
					REG_PERSIST: begin
						persist_q <= cfg_data[15:0];
						kick_q    <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	fvn_weights u_weights (
		.clk             (clk),
		.arst_n          (arst_n),
		.kick            (kick_q),
		.octave_count    (octaves_q),
		.persistence_q16 (persist_q),
		.weights         (wts),
		.busy            (wt_busy)
	);

	assign busy = wt_busy;

	logic accept;
	assign accept = start && !wt_busy;

	// Valid bits travel alongside the data, one per stage.
	logic [9:1] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[8:1], accept};
	end

	// Stage 1: split the scaled position, seed-mix and shift-xor both points.
	logic [63:0]        pos_ext;
	logic [L-1:0][31:0] ix_c, na_c, nb_c;
	logic [L-1:0][15:0] fx_c;
	logic [L-1:0][63:0] scaled_c;
	logic [L-1:0][FRAC_BITS+15:0] fwide_c;

	always_comb begin
		pos_ext = {{(64-POS_W){position[POS_W-1]}}, position};
		for (int i = 0; i < L; i++) begin
			scaled_c[i] = pos_ext << i;
			ix_c[i]     = scaled_c[i][FRAC_BITS+31:FRAC_BITS];
			fwide_c[i]  = {scaled_c[i][FRAC_BITS-1:0], 16'd0} >> FRAC_BITS;
			fx_c[i]     = fwide_c[i][15:0];
			na_c[i]     = ix_c[i] + seed57_q;
			nb_c[i]     = ix_c[i] + 32'd1 + seed57_q;
		end
	end

	logic [L-1:0][31:0] na_s1, nb_s1;
	logic [L-1:0][15:0] fx_s1;
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			na_s1[i] <= (na_c[i] << 13) ^ na_c[i];
			nb_s1[i] <= (nb_c[i] << 13) ^ nb_c[i];
			fx_s1[i] <= fx_c[i];
		end
	end

	// Stage 2: square the hash words and the fraction.
	logic [L-1:0][31:0] na_s2, nb_s2, sqa_s2, sqb_s2, fx2_s2;
	logic [L-1:0][15:0] fx_s2;
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			na_s2[i]  <= na_s1[i];
			nb_s2[i]  <= nb_s1[i];
			sqa_s2[i] <= na_s1[i] * na_s1[i];
			sqb_s2[i] <= nb_s1[i] * nb_s1[i];
			fx2_s2[i] <= {16'd0, fx_s1[i]} * {16'd0, fx_s1[i]};
			fx_s2[i]  <= fx_s1[i];
		end
	end

	// Stage 3: polynomial term of the hash; smoothstep weight.
	logic [L-1:0][17:0] w_c;
	logic [L-1:0][49:0] tw_c;
	always_comb begin
		for (int i = 0; i < L; i++) begin
			w_c[i]  = 18'd196608 - {1'b0, fx_s2[i], 1'b0};
			tw_c[i] = {18'd0, fx2_s2[i]} * {32'd0, w_c[i]};
		end
	end

	logic [L-1:0][31:0] na_s3, nb_s3, pa_s3, pb_s3;
	logic [L-1:0][15:0] t_s3;
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			na_s3[i] <= na_s2[i];
			nb_s3[i] <= nb_s2[i];
			pa_s3[i] <= sqa_s2[i] * HASH_M1 + HASH_A1;
			pb_s3[i] <= sqb_s2[i] * HASH_M1 + HASH_A1;
			t_s3[i]  <= tw_c[i][47:32];
		end
	end

	// Stage 4: finish the hash, keep 16 bits of the masked 31-bit value.
	logic [L-1:0][31:0] ha_c, hb_c;
	always_comb begin
		for (int i = 0; i < L; i++) begin
			ha_c[i] = na_s3[i] * pa_s3[i] + HASH_A2;
			hb_c[i] = nb_s3[i] * pb_s3[i] + HASH_A2;
		end
	end

	logic [L-1:0][15:0] va_s4, vb_s4, t_s4;
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			va_s4[i] <= ha_c[i][30:15];
			vb_s4[i] <= hb_c[i][30:15];
			t_s4[i]  <= t_s3[i];
		end
	end

	// Stage 5: blend neighbouring lattice values.
	logic [L-1:0][32:0] blend_c;
	always_comb begin
		for (int i = 0; i < L; i++) begin
			blend_c[i] = {17'd0, va_s4[i]} * (33'd65536 - {17'd0, t_s4[i]})
				+ {17'd0, vb_s4[i]} * {17'd0, t_s4[i]};
		end
	end

	logic [L-1:0][15:0] s_s5;
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) s_s5[i] <= blend_c[i][31:16];
	end

	// Stage 6: weight each octave; unused octaves carry zero weight.
	logic [L-1:0][32:0] wp_s6;
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) wp_s6[i] <= {17'd0, s_s5[i]} * {16'd0, wts.amp[i]};
	end

	// Stage 7: sum the octaves.
	logic [V_W-1:0] vsum_c;
	always_comb begin
		vsum_c = '0;
		for (int i = 0; i < L; i++) vsum_c = vsum_c + V_W'(wp_s6[i]);
	end

	logic [V_W-1:0] v_s7;
	always_ff @(posedge clk) v_s7 <= vsum_c;

	// Stage 8: normalize, reciprocal cut into two partial products.
	logic [V_W+RLO_W-1:0] plo_s8;
	logic [V_W+RHI_W-1:0] phi_s8;
	always_ff @(posedge clk) begin
		plo_s8 <= {{RLO_W{1'b0}}, v_s7} * {{V_W{1'b0}}, wts.recip[RLO_W-1:0]};
		phi_s8 <= {{RHI_W{1'b0}}, v_s7} * {{V_W{1'b0}}, wts.recip[RECIP_W-1:RLO_W]};
	end

	// Stage 9: combine, drop 40 fraction bits, saturate.
	logic [V_W+RECIP_W-1:0] full_c;
	logic [V_W+RECIP_W-41:0] r_c;
	always_comb begin
		full_c = {phi_s8, {RLO_W{1'b0}}} + (V_W + RECIP_W)'(plo_s8);
		r_c    = full_c[V_W+RECIP_W-1:40];
	end

	logic [15:0] out_s9;
	always_ff @(posedge clk) begin
		out_s9 <= (r_c > (V_W + RECIP_W - 40)'(65535)) ? 16'hFFFF : r_c[15:0];
	end

	assign done        = vld_q[9];
	assign noise_value = out_s9;
endmodule
